FILE: hw/rtl/crp_pkg.sv
// Shared constants, types and helper functions for the caption pacing block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package crp_pkg;

  localparam int unsigned STREAM_BYTES = 512;
  localparam int unsigned FINAL_BYTES  = 512;
  localparam int unsigned OUT_MAX      = 64;

  localparam int unsigned MAX_BYTES = (STREAM_BYTES > FINAL_BYTES) ? STREAM_BYTES : FINAL_BYTES;
  localparam int unsigned S_AW      = $clog2(STREAM_BYTES);
  localparam int unsigned F_AW      = $clog2(FINAL_BYTES);
  localparam int unsigned LEN_W     = $clog2(MAX_BYTES + 1);

  localparam int unsigned WGT_W = 13;
  localparam int unsigned ACC_W = $clog2(MAX_BYTES * 7200 + 1);
  localparam logic [WGT_W-1:0] W_MULTI = 13'd7200;
  localparam logic [WGT_W-1:0] W_SPACE = 13'd900;
  localparam logic [WGT_W-1:0] W_ALNUM = 13'd2600;
  localparam logic [WGT_W-1:0] W_OTHER = 13'd1800;

  localparam int unsigned CAP_W      = 7;
  localparam int unsigned VIS_W      = 10;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [2:0] FUNC_STREAM = 3'd0;
  localparam logic [2:0] FUNC_FINAL  = 3'd1;
  localparam logic [2:0] FUNC_RECV   = 3'd2;
  localparam logic [2:0] FUNC_PLAY   = 3'd3;
  localparam logic [2:0] FUNC_DONE   = 3'd4;
  localparam logic [2:0] FUNC_SHOW   = 3'd5;
  localparam logic [2:0] FUNC_CLEAR  = 3'd6;

  typedef enum logic [2:0] {
    OP_STREAM,
    OP_FINAL,
    OP_RECV,
    OP_PLAY,
    OP_DONE,
    OP_SHOW,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  text_byte;
    logic        text_first;
    logic [31:0] byte_count;
    logic        force_full;
  } cmd_t;

  // Length of the UTF-8 sequence that a lead byte announces, before clipping.
  function automatic logic [2:0] seq_len_raw(input logic [7:0] lead);
    logic [2:0] n;
    n = 3'd1;
    if (lead inside {[8'hc2:8'hdf]}) begin
      n = 3'd2;
    end else if (lead inside {[8'he0:8'hef]}) begin
      n = 3'd3;
    end else if (lead inside {[8'hf0:8'hf4]}) begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [WGT_W-1:0] seq_weight(input logic [7:0] lead, input logic multi);
    logic [WGT_W-1:0] w;
    if (multi) begin
      w = W_MULTI;
    end else if (lead inside {8'h20, [8'h09:8'h0d]}) begin
      w = W_SPACE;
    end else if (lead inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) begin
      w = W_ALNUM;
    end else begin
      w = W_OTHER;
    end
    return w;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

FILE: hw/rtl/crp_front.sv
// Front end: takes input words, decodes the function code and drops words
// that have no effect. Depends on crp_pkg.
`timescale 1ns / 1ps
module crp_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        text_byte_i,
  input  logic              text_first_i,
  input  logic [31:0]       byte_count_i,
  input  logic              force_full_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output crp_pkg::cmd_t     cmd_o
);

  logic keep;

  always_comb begin
    keep      = 1'b1;
    cmd_o.op  = crp_pkg::OP_SHOW;
    case (func_i)
      crp_pkg::FUNC_STREAM: begin
        cmd_o.op = crp_pkg::OP_STREAM;
        keep     = text_byte_i != 8'd0;
      end
      crp_pkg::FUNC_FINAL: begin
        cmd_o.op = crp_pkg::OP_FINAL;
        keep     = (text_byte_i != 8'd0) || text_first_i;
      end
      crp_pkg::FUNC_RECV:  cmd_o.op = crp_pkg::OP_RECV;
      crp_pkg::FUNC_PLAY:  cmd_o.op = crp_pkg::OP_PLAY;
      crp_pkg::FUNC_DONE:  cmd_o.op = crp_pkg::OP_DONE;
      crp_pkg::FUNC_SHOW:  cmd_o.op = crp_pkg::OP_SHOW;
      crp_pkg::FUNC_CLEAR: cmd_o.op = crp_pkg::OP_CLEAR;
      default:             keep     = 1'b0;
    endcase
    cmd_o.text_byte  = text_byte_i;
    cmd_o.text_first = text_first_i;
    cmd_o.byte_count = byte_count_i;
    cmd_o.force_full = force_full_i;
  end

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i && keep;

endmodule

FILE: hw/rtl/crp_fifo.sv
// Short command queue between the front end and the back end.
// Depends on crp_pkg.
`timescale 1ns / 1ps
module crp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  crp_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output crp_pkg::cmd_t cmd_o
);

  crp_pkg::cmd_t                   mem_q [crp_pkg::FIFO_DEPTH];
  logic [crp_pkg::FIFO_AW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [crp_pkg::FIFO_AW:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = cnt_q == (crp_pkg::FIFO_AW + 1)'(crp_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == crp_pkg::FIFO_AW'(crp_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == crp_pkg::FIFO_AW'(crp_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/crp_back.sv
// Back end: text stores, audio counters, pacing walk and tail output register.
// Depends on crp_pkg.
`timescale 1ns / 1ps
module crp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [crp_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        empty_i,
  input  crp_pkg::cmd_t               cmd_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_valid_o,
  output logic                        last_o,
  output logic [crp_pkg::VIS_W-1:0]   visible_sequences_o
);

  localparam int unsigned LW = crp_pkg::LEN_W;
  localparam int unsigned AW = crp_pkg::ACC_W;
  localparam int unsigned PA_W = 32 + AW;
  localparam int unsigned PB_W = 33 + AW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIM_RD, ST_TRIM_CHK, ST_TOT_RD, ST_TOT_DAT, ST_WALK_RD, ST_WALK_DAT,
    ST_WALK_MUL, ST_WALK_CHK, ST_TAIL, ST_SKIP_RD, ST_SKIP_DAT, ST_EMIT, ST_EMIT_RD,
    ST_EMPTY
  } state_e;

  function automatic logic [crp_pkg::S_AW-1:0] s_at(input logic [crp_pkg::S_AW-1:0] h,
                                                      input logic [LW-1:0] o);
    logic [LW:0] sum;
    sum = (LW + 1)'(h) + (LW + 1)'(o);
    if (sum >= (LW + 1)'(crp_pkg::STREAM_BYTES)) begin
      sum = sum - (LW + 1)'(crp_pkg::STREAM_BYTES);
    end
    return sum[crp_pkg::S_AW-1:0];
  endfunction

  function automatic logic [crp_pkg::F_AW-1:0] f_at(input logic [crp_pkg::F_AW-1:0] h,
                                                      input logic [LW-1:0] o);
    logic [LW:0] sum;
    sum = (LW + 1)'(h) + (LW + 1)'(o);
    if (sum >= (LW + 1)'(crp_pkg::FINAL_BYTES)) begin
      sum = sum - (LW + 1)'(crp_pkg::FINAL_BYTES);
    end
    return sum[crp_pkg::F_AW-1:0];
  endfunction

  state_e                        state_q, state_d;
  logic [crp_pkg::S_AW-1:0]      s_head_q, s_head_d;
  logic [crp_pkg::F_AW-1:0]      f_head_q, f_head_d;
  logic [LW-1:0]                 s_len_q, s_len_d, f_len_q, f_len_d;
  logic [31:0]                   recv_q, recv_d, play_q, play_d;
  logic                          done_q, done_d;
  logic [LW-1:0]                 rev_q, rev_d;
  logic [crp_pkg::CAP_W-1:0]     cap_q, cap_d;
  logic [7:0]                    pend_q, pend_d;
  logic                          rd_fin_q, rd_fin_d;
  logic                          force_q, force_d, pace_q, pace_d, scaled_q, scaled_d;
  logic [LW-1:0]                 off_q, off_d, k_q, k_d, seqs_q, seqs_d, tlen_q, tlen_d;
  logic [AW-1:0]                 acc_q, acc_d, total_q, total_d;
  logic [2:0]                    nlen_q, nlen_d;
  logic [PA_W-1:0]               prod_a_q, prod_a_d;
  logic [PB_W-1:0]               prod_b_q, prod_b_d;
  logic [7:0]                    obyte_q, obyte_d;
  logic                          obv_q, obv_d, olast_q, olast_d, ovalid_q, ovalid_d;
  logic [crp_pkg::VIS_W-1:0]     ovis_q, ovis_d;

  logic [7:0]                    s_mem [crp_pkg::STREAM_BYTES];
  logic [7:0]                    f_mem [crp_pkg::FINAL_BYTES];
  logic [7:0]                    s_rd_q, f_rd_q, rdata;
  logic                          s_we, f_we;
  logic [crp_pkg::S_AW-1:0]      s_waddr;
  logic [crp_pkg::F_AW-1:0]      f_waddr;
  logic [7:0]                    wdata;

  logic [LW-1:0]                 slen, rem, seq_n, eff_len;
  logic [2:0]                    raw_n;
  logic [crp_pkg::WGT_W-1:0]     wgt;
  logic [crp_pkg::F_AW-1:0]      eff_head;
  logic [32:0]                   sat_sum;
  logic                          fin_sel, can_load, pass, scaled_ok;
  logic [crp_pkg::CAP_W-1:0]     cap_eff, maxb;

  assign rdata   = rd_fin_q ? f_rd_q : s_rd_q;
  assign slen    = rd_fin_q ? f_len_q : s_len_q;
  assign rem     = slen - off_q;
  assign raw_n   = crp_pkg::seq_len_raw(rdata);
  assign seq_n   = (LW'(raw_n) > rem) ? rem : LW'(raw_n);
  assign wgt     = crp_pkg::seq_weight(rdata, seq_n > LW'(1));
  assign can_load = !ovalid_q || res_ready_i;
  assign cap_eff = (cap_q == '0) ? crp_pkg::CAP_W'(1) : cap_q;
  assign maxb    = ((cap_eff - 1'b1) > crp_pkg::CAP_W'(crp_pkg::OUT_MAX))
                   ? crp_pkg::CAP_W'(crp_pkg::OUT_MAX) : cap_eff - 1'b1;
  // floor(received * acc / total) <= played  <=>  received * acc < (played + 1) * total
  assign scaled_ok = PB_W'(prod_a_q) < prod_b_q;
  assign pass = pace_q && (force_q || (scaled_q ? scaled_ok : (32'(acc_q) <= play_q)));

  always_comb begin
    state_d = state_q;   s_head_d = s_head_q; f_head_d = f_head_q;
    s_len_d = s_len_q;   f_len_d = f_len_q;   recv_d = recv_q;   play_d = play_q;
    done_d  = done_q;    rev_d   = rev_q;     pend_d = pend_q;   rd_fin_d = rd_fin_q;
    force_d = force_q;   pace_d  = pace_q;    scaled_d = scaled_q;
    off_d   = off_q;     k_d     = k_q;       seqs_d = seqs_q;   tlen_d = tlen_q;
    acc_d   = acc_q;     total_d = total_q;   nlen_d = nlen_q;
    prod_a_d = prod_a_q; prod_b_d = prod_b_q;
    obyte_d = obyte_q;   obv_d = obv_q;       olast_d = olast_q; ovis_d = ovis_q;
    ovalid_d = ovalid_q && !res_ready_i;
    cap_d   = cfg_we_i ? cfg_wdata_i : cap_q;
    pop_o   = 1'b0;
    s_we    = 1'b0;      f_we = 1'b0;
    s_waddr = '0;        f_waddr = '0;        wdata = cmd_i.text_byte;
    sat_sum = 33'(recv_q) + 33'(cmd_i.byte_count);
    fin_sel = done_q && (f_len_q != '0);
    eff_len = cmd_i.text_first ? '0 : f_len_q;
    eff_head = cmd_i.text_first ? '0 : f_head_q;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            crp_pkg::OP_STREAM: begin
              if (s_len_q >= LW'(crp_pkg::STREAM_BYTES)) begin
                s_head_d = s_at(s_head_q, LW'(1));
                s_len_d  = s_len_q - 1'b1;
                pend_d   = cmd_i.text_byte;
                rd_fin_d = 1'b0;
                off_d    = '0;
                state_d  = ST_TRIM_RD;
              end else begin
                s_we    = 1'b1;
                s_waddr = s_at(s_head_q, s_len_q);
                s_len_d = s_len_q + 1'b1;
              end
            end
            crp_pkg::OP_FINAL: begin
              f_len_d  = eff_len;
              f_head_d = eff_head;
              if (cmd_i.text_byte != 8'd0) begin
                if (eff_len >= LW'(crp_pkg::FINAL_BYTES)) begin
                  f_head_d = f_at(eff_head, LW'(1));
                  f_len_d  = eff_len - 1'b1;
                  pend_d   = cmd_i.text_byte;
                  rd_fin_d = 1'b1;
                  off_d    = '0;
                  state_d  = ST_TRIM_RD;
                end else begin
                  f_we    = 1'b1;
                  f_waddr = f_at(eff_head, eff_len);
                  f_len_d = eff_len + 1'b1;
                end
              end
            end
            crp_pkg::OP_RECV: begin
              recv_d = sat_sum[32] ? '1 : sat_sum[31:0];
            end
            crp_pkg::OP_PLAY: begin
              sat_sum = 33'(play_q) + 33'(cmd_i.byte_count);
              play_d  = sat_sum[32] ? '1 : sat_sum[31:0];
            end
            crp_pkg::OP_DONE: done_d = 1'b1;
            crp_pkg::OP_CLEAR: begin
              s_head_d = '0; f_head_d = '0; s_len_d = '0; f_len_d = '0;
              recv_d = '0;   play_d = '0;   done_d = 1'b0; rev_d = '0;
            end
            crp_pkg::OP_SHOW: begin
              rd_fin_d = fin_sel;
              force_d  = cmd_i.force_full;
              pace_d   = cmd_i.force_full ||
                         ((play_q != '0) && ((fin_sel ? f_len_q : s_len_q) != '0));
              scaled_d = !cmd_i.force_full && done_q && (recv_q != '0);
              off_d = '0; k_d = '0; seqs_d = '0; acc_d = '0; total_d = '0;
              state_d = (pace_d && scaled_d) ? ST_TOT_RD : ST_WALK_RD;
            end
            default: ;
          endcase
        end
      end
      // Full store: after the oldest byte, continuation bytes at the head go too.
      ST_TRIM_RD: state_d = ST_TRIM_CHK;
      ST_TRIM_CHK: begin
        if (rd_fin_q) begin
          if ((f_len_q != '0) && crp_pkg::is_cont(rdata)) begin
            f_head_d = f_at(f_head_q, LW'(1));
            f_len_d  = f_len_q - 1'b1;
            state_d  = ST_TRIM_RD;
          end else begin
            f_we    = 1'b1;
            f_waddr = f_at(f_head_q, f_len_q);
            wdata   = pend_q;
            f_len_d = f_len_q + 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          if ((s_len_q != '0) && crp_pkg::is_cont(rdata)) begin
            s_head_d = s_at(s_head_q, LW'(1));
            s_len_d  = s_len_q - 1'b1;
            state_d  = ST_TRIM_RD;
          end else begin
            s_we    = 1'b1;
            s_waddr = s_at(s_head_q, s_len_q);
            wdata   = pend_q;
            s_len_d = s_len_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_TOT_RD: begin
        if (off_q >= slen) begin
          off_d   = '0;
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_TOT_DAT;
        end
      end
      ST_TOT_DAT: begin
        total_d = total_q + AW'(wgt);
        off_d   = off_q + seq_n;
        state_d = ST_TOT_RD;
      end
      ST_WALK_RD: state_d = (off_q >= slen) ? ST_TAIL : ST_WALK_DAT;
      ST_WALK_DAT: begin
        nlen_d  = seq_n[2:0];
        acc_d   = acc_q + AW'(wgt);
        state_d = ST_WALK_MUL;
      end
      ST_WALK_MUL: begin
        prod_a_d = PA_W'(recv_q) * PA_W'(acc_q);
        prod_b_d = (PB_W'(play_q) + 1'b1) * PB_W'(total_q);
        state_d  = ST_WALK_CHK;
      end
      // Pacing stops at the first sequence not yet played; revealed ones stay.
      ST_WALK_CHK: begin
        if (pass) begin
          seqs_d  = seqs_q + 1'b1;
          k_d     = k_q + 1'b1;
          off_d   = off_q + LW'(nlen_q);
          state_d = ST_WALK_RD;
        end else begin
          pace_d = 1'b0;
          if (k_q < rev_q) begin
            k_d     = k_q + 1'b1;
            off_d   = off_q + LW'(nlen_q);
            state_d = ST_WALK_RD;
          end else begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        tlen_d = off_q;
        if (seqs_q >= rev_q) begin
          rev_d = seqs_q;
        end
        off_d   = (off_q > LW'(maxb)) ? off_q - LW'(maxb) : '0;
        state_d = ST_SKIP_RD;
      end
      ST_SKIP_RD: state_d = (off_q >= tlen_q) ? ST_EMPTY : ST_SKIP_DAT;
      ST_SKIP_DAT: begin
        if (crp_pkg::is_cont(rdata)) begin
          off_d   = off_q + 1'b1;
          state_d = ST_SKIP_RD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          obyte_d  = rdata;
          obv_d    = 1'b1;
          olast_d  = (off_q + 1'b1) == tlen_q;
          ovis_d   = rev_q[crp_pkg::VIS_W-1:0];
          off_d    = off_q + 1'b1;
          state_d  = ((off_q + 1'b1) == tlen_q) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMPTY: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          obyte_d  = 8'd0;
          obv_d    = 1'b0;
          olast_d  = 1'b1;
          ovis_d   = rev_q[crp_pkg::VIS_W-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  s_head_q <= '0; f_head_q <= '0; s_len_q <= '0; f_len_q <= '0;
      recv_q  <= '0;       play_q <= '0;   done_q <= 1'b0; rev_q <= '0;
      cap_q   <= crp_pkg::CAP_W'(65);
      rd_fin_q <= 1'b0;    force_q <= 1'b0; pace_q <= 1'b0; scaled_q <= 1'b0;
      off_q   <= '0;       k_q <= '0;      seqs_q <= '0;   tlen_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;  s_head_q <= s_head_d; f_head_q <= f_head_d;
      s_len_q <= s_len_d;  f_len_q <= f_len_d;
      recv_q  <= recv_d;   play_q <= play_d; done_q <= done_d; rev_q <= rev_d;
      cap_q   <= cap_d;
      rd_fin_q <= rd_fin_d; force_q <= force_d; pace_q <= pace_d; scaled_q <= scaled_d;
      off_q   <= off_d;    k_q <= k_d;     seqs_q <= seqs_d; tlen_q <= tlen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;   acc_q <= acc_d;     total_q <= total_d; nlen_q <= nlen_d;
    prod_a_q <= prod_a_d; prod_b_q <= prod_b_d;
    obyte_q  <= obyte_d;  obv_q <= obv_d;     olast_q <= olast_d; ovis_q <= ovis_d;
  end

  // Text stores: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= wdata;
    end
    s_rd_q <= s_mem[s_at(s_head_q, off_q)];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      f_mem[f_waddr] <= wdata;
    end
    f_rd_q <= f_mem[f_at(f_head_q, off_q)];
  end

  assign res_valid_o         = ovalid_q;
  assign out_byte_o          = obyte_q;
  assign out_valid_o         = obv_q;
  assign last_o              = olast_q;
  assign visible_sequences_o = ovis_q;

endmodule

FILE: hw/rtl/caption_pacing_reveal.sv
// Steps: a non-show word is applied from the idle state; a write into a full store
// first reads and drops the oldest byte and the continuation bytes after it. A show word
// sums the sequence weights (only after completion with audio received), walks the
// sequences for pacing, skips head bytes and emits the tail bytes, each via a store read.
// Input: words are queued four deep, so the front end keeps taking words until the queue is full.
// Reset (rst_ni low, asynchronous): stores empty, counters and flags zero, capacity 65.
`timescale 1ns / 1ps
module caption_pacing_reveal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [crp_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  func_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        text_first_i,
  input  logic [31:0]                 byte_count_i,
  input  logic                        force_full_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_valid_o,
  output logic                        last_o,
  output logic [crp_pkg::VIS_W-1:0]   visible_sequences_o
);

  crp_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, full, empty;

  crp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .text_byte_i  (text_byte_i),
    .text_first_i (text_first_i),
    .byte_count_i (byte_count_i),
    .force_full_i (force_full_i),
    .fifo_full_i  (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  crp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  crp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .empty_i             (empty),
    .cmd_i               (head_cmd),
    .pop_o               (pop),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .out_byte_o          (out_byte_o),
    .out_valid_o         (out_valid_o),
    .last_o              (last_o),
    .visible_sequences_o (visible_sequences_o)
  );

endmodule

FILE: hw/rtl/crp_checker.sv
// Port-level checks on the result channel of caption_pacing_reveal, bound to
// the top level. Depends on crp_pkg.
`timescale 1ns / 1ps
module crp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_o,
  input logic                       res_ready_i,
  input logic [7:0]                 out_byte_o,
  input logic                       out_valid_o,
  input logic                       last_o,
  input logic [crp_pkg::VIS_W-1:0]  visible_sequences_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> $stable(out_byte_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // An empty caption is a single word that closes the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> last_o && out_byte_o == 8'd0)
    else $error("empty caption word malformed");

  // The revealed count never shrinks within one request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !last_o |=>
      !res_valid_o || visible_sequences_o == $past(visible_sequences_o))
    else $error("revealed count changed inside a request");

endmodule

bind caption_pacing_reveal crp_checker u_crp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_o         (res_valid_o),
  .res_ready_i         (res_ready_i),
  .out_byte_o          (out_byte_o),
  .out_valid_o         (out_valid_o),
  .last_o              (last_o),
  .visible_sequences_o (visible_sequences_o)
);

FILE: verif/testbench.sv
// Self-checking testbench for caption_pacing_reveal: directed table, then random caption
// episodes, with a built-in predictor of the pacing and reveal behavior. Depends on crp_pkg.
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned STORE_BYTES = 512;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 2000;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct {
    logic [7:0] b;
    logic       v;
    logic       l;
    logic [9:0] vis;
  } caption_word_t;

  typedef struct {
    logic [2:0]  f;
    logic [7:0]  tb;
    logic        first;
    logic [31:0] cnt;
    logic        frc;
    bit          chk;
    logic        exp_v;
    logic [9:0]  exp_vis;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [crp_pkg::CAP_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] func = '0;
  logic [7:0] text_byte = '0;
  logic text_first = 1'b0;
  logic [31:0] byte_count = '0;
  logic force_full = 1'b0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_valid;
  logic last;
  logic [crp_pkg::VIS_W-1:0] visible_sequences;

  caption_pacing_reveal u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .func_i              (func),
    .text_byte_i         (text_byte),
    .text_first_i        (text_first),
    .byte_count_i        (byte_count),
    .force_full_i        (force_full),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .out_byte_o          (out_byte),
    .out_valid_o         (out_valid),
    .last_o              (last),
    .visible_sequences_o (visible_sequences)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state; index 0 is the streamed text, index 1 the final text.
  logic [7:0]  text_mem [2][STORE_BYTES];
  int unsigned text_len [2];
  logic [31:0] recv_bytes, played_bytes;
  bit          stream_done;
  int unsigned revealed;
  int unsigned capacity;

  caption_word_t caption_q[$];
  int unsigned   errors = 0;
  int unsigned   words_seen = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycles = 0;

  function automatic void clear_caption();
    text_len[0] = 0;
    text_len[1] = 0;
    recv_bytes = '0;
    played_bytes = '0;
    stream_done = 1'b0;
    revealed = 0;
  endfunction

  function automatic void store_text(int sel, logic [7:0] b);
    int unsigned drop;
    if (b == 8'h00) return;
    if (text_len[sel] >= STORE_BYTES) begin
      drop = 1;
      while (drop < text_len[sel] && text_mem[sel][drop][7:6] == 2'b10) drop++;
      for (int unsigned i = 0; i + drop < text_len[sel]; i++) begin
        text_mem[sel][i] = text_mem[sel][i + drop];
      end
      text_len[sel] -= drop;
    end
    text_mem[sel][text_len[sel]] = b;
    text_len[sel]++;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int unsigned utf8_len(int sel, int unsigned off, int unsigned len);
    logic [7:0] lead;
    int unsigned n;
    lead = text_mem[sel][off];
    n = 1;
    if (lead >= 8'hc2 && lead <= 8'hdf) n = 2;
    else if (lead >= 8'he0 && lead <= 8'hef) n = 3;
    else if (lead >= 8'hf0 && lead <= 8'hf4) n = 4;
    if (n > len - off) n = len - off;
    return n;
  endfunction

  function automatic longint unsigned pace_weight(logic [7:0] lead, int unsigned n);
    if (n > 1) return 7200;
    if (lead == 8'h20 || (lead >= 8'h09 && lead <= 8'h0d)) return 900;
    if ((lead >= 8'h30 && lead <= 8'h39) || (lead >= 8'h41 && lead <= 8'h5a) ||
        (lead >= 8'h61 && lead <= 8'h7a)) return 2600;
    return 1800;
  endfunction

  function automatic int unsigned played_prefix(int sel, int unsigned len);
    longint unsigned total, acc, target;
    int unsigned off, n, shown;
    total = 0;
    acc = 0;
    shown = 0;
    if (played_bytes == 0 || len == 0) return 0;
    if (stream_done) begin
      off = 0;
      while (off < len) begin
        n = utf8_len(sel, off, len);
        total += pace_weight(text_mem[sel][off], n);
        off += n;
      end
    end
    off = 0;
    while (off < len) begin
      n = utf8_len(sel, off, len);
      acc += pace_weight(text_mem[sel][off], n);
      target = acc;
      if (total > 0 && recv_bytes > 0) target = longint'(recv_bytes) * acc / total;
      if (target > longint'(played_bytes)) break;
      off += n;
      shown = off;
    end
    return shown;
  endfunction

  function automatic void show_caption(logic frc);
    int sel;
    int unsigned slen, length, seqs, off, k, maxb, cap;
    caption_word_t w;
    sel = (stream_done && text_len[1] > 0) ? 1 : 0;
    slen = text_len[sel];
    length = frc ? slen : played_prefix(sel, slen);
    seqs = 0;
    off = 0;
    while (off < length) begin
      off += utf8_len(sel, off, slen);
      seqs++;
    end
    if (seqs < revealed) begin
      off = 0;
      k = 0;
      while (off < slen && k < revealed) begin
        off += utf8_len(sel, off, slen);
        k++;
      end
      length = off;
    end else begin
      revealed = seqs;
    end
    cap = (capacity == 0) ? 1 : capacity;
    maxb = cap - 1;
    if (maxb > crp_pkg::OUT_MAX) maxb = crp_pkg::OUT_MAX;
    off = (length > maxb) ? length - maxb : 0;
    while (off < length && text_mem[sel][off][7:6] == 2'b10) off++;
    w.vis = revealed[9:0];
    if (off >= length) begin
      w.b = 8'h00;
      w.v = 1'b0;
      w.l = 1'b1;
      caption_q.push_back(w);
    end else begin
      for (k = off; k < length; k++) begin
        w.b = text_mem[sel][k];
        w.v = 1'b1;
        w.l = (k + 1 == length);
        caption_q.push_back(w);
      end
    end
  endfunction

  function automatic void apply_word(logic [2:0] f, logic [7:0] tb, logic first,
                                     logic [31:0] cnt, logic frc);
    case (f)
      crp_pkg::FUNC_STREAM: store_text(0, tb);
      crp_pkg::FUNC_FINAL: begin
        if (first) text_len[1] = 0;
        store_text(1, tb);
      end
      crp_pkg::FUNC_RECV: recv_bytes = sat_add(recv_bytes, cnt);
      crp_pkg::FUNC_PLAY: played_bytes = sat_add(played_bytes, cnt);
      crp_pkg::FUNC_DONE: stream_done = 1'b1;
      crp_pkg::FUNC_SHOW: show_caption(frc);
      crp_pkg::FUNC_CLEAR: clear_caption();
      default: ;
    endcase
  endfunction

  // Valid is only lowered when a gap is drawn, so a back-to-back word never sees
  // two assignments to it in one step.
  task automatic send_word(logic [2:0] f, logic [7:0] tb, logic first, logic [31:0] cnt,
                           logic frc);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func <= f;
    text_byte <= tb;
    text_first <= first;
    byte_count <= cnt;
    force_full <= frc;
    do @(posedge clk_i); while (!in_ready);
    apply_word(f, tb, first, cnt, frc);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (caption_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value[crp_pkg::CAP_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    capacity = value & 32'h7f;
  endtask

  task automatic send_char(logic [2:0] f);
    int unsigned kind, n;
    logic [7:0] lead;
    kind = $urandom_range(0, 9);
    n = 1;
    case (kind)
      0, 1, 2: lead = 8'h61 + 8'($urandom_range(0, 25));
      3: lead = 8'h30 + 8'($urandom_range(0, 9));
      4: lead = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(0, 4));
      5: lead = 8'h21 + 8'($urandom_range(0, 14));
      6: begin lead = 8'hc2 + 8'($urandom_range(0, 29)); n = 2; end
      7: begin lead = 8'he0 + 8'($urandom_range(0, 15)); n = 3; end
      8: begin lead = 8'hf0 + 8'($urandom_range(0, 4)); n = 4; end
      default: lead = 8'($urandom_range(1, 255));
    endcase
    send_word(f, lead, 1'b0, '0, 1'b0);
    for (int unsigned i = 1; i < n; i++) begin
      send_word(f, 8'h80 | 8'($urandom_range(0, 63)), 1'b0, '0, 1'b0);
    end
  endtask

  function automatic logic [31:0] audio_amount();
    return ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 20000));
  endfunction

  // One caption: text streamed in, audio paced out with shows along the way, and
  // sometimes a final text and completion.
  task automatic caption_episode();
    int unsigned chars, rounds;
    if ($urandom_range(0, 2) == 0) send_word(crp_pkg::FUNC_CLEAR, '0, 1'b0, '0, 1'b0);
    chars = $urandom_range(1, 12);
    repeat (chars) send_char(crp_pkg::FUNC_STREAM);
    if ($urandom_range(0, 1) == 0) send_word(crp_pkg::FUNC_RECV, '0, 1'b0, audio_amount(), 1'b0);
    rounds = $urandom_range(1, 4);
    repeat (rounds) begin
      send_word(crp_pkg::FUNC_PLAY, '0, 1'b0, 32'($urandom_range(0, 8000)), 1'b0);
      send_word(crp_pkg::FUNC_SHOW, '0, 1'b0, '0, $urandom_range(0, 7) == 0);
    end
    if ($urandom_range(0, 1) == 0) begin
      send_word(crp_pkg::FUNC_FINAL, 8'h41 + 8'($urandom_range(0, 25)), 1'b1, '0, 1'b0);
      repeat ($urandom_range(0, 10)) send_char(crp_pkg::FUNC_FINAL);
      send_word(crp_pkg::FUNC_RECV, '0, 1'b0, audio_amount(), 1'b0);
      send_word(crp_pkg::FUNC_DONE, '0, 1'b0, '0, 1'b0);
      send_word(crp_pkg::FUNC_PLAY, '0, 1'b0, audio_amount(), 1'b0);
      send_word(crp_pkg::FUNC_SHOW, '0, 1'b0, '0, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic noise_word();
    send_word(3'($urandom_range(0, 6)), 8'($urandom), 1'($urandom), $urandom, 1'($urandom));
  endtask

  // Result side: random stalls, plus one long hold-off so the input queue fills up.
  initial begin : result_sink
    int unsigned stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (!held && words_seen >= 20) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      do @(posedge clk_i); while (!res_valid);
    end
  end

  always @(posedge clk_i) begin
    caption_word_t w;
    if (rst_ni && res_valid && res_ready) begin
      words_seen++;
      if (caption_q.size() == 0) begin
        $error("unexpected word: out_byte %0h out_valid %0b last %0b", out_byte, out_valid,
               last);
        errors++;
      end else begin
        w = caption_q.pop_front();
        if (out_valid !== w.v) begin
          $error("out_valid: expected %0b, actual %0b", w.v, out_valid); errors++;
        end
        if (w.v && out_byte !== w.b) begin
          $error("out_byte: expected %0h, actual %0h", w.b, out_byte); errors++;
        end
        if (!w.v && out_byte !== 8'h00) begin
          $error("out_byte: expected 0, actual %0h", out_byte); errors++;
        end
        if (last !== w.l) begin
          $error("last: expected %0b, actual %0b", w.l, last); errors++;
        end
        if (visible_sequences !== w.vis) begin
          $error("visible_sequences: expected %0d, actual %0d", w.vis, visible_sequences);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    table_row_t rows[$];
    int unsigned caps[7];
    int unsigned before_q;
    caption_word_t w;
    rows = '{
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b0, 1'b1, 1'b0, 10'd0},
      '{FUNC_UNUSED,          8'hff, 1'b1, 32'hffff_ffff,  1'b1, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'h48, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'h20, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'hc3, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'ha9, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'h00, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'he2, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b0, 1'b1, 1'b0, 10'd0},
      '{crp_pkg::FUNC_PLAY,   8'h00, 1'b0, 32'd2600,       1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_RECV,   8'h00, 1'b0, 32'hffff_ffff,  1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_RECV,   8'h00, 1'b0, 32'd5,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_PLAY,   8'h00, 1'b0, 32'hffff_ffff,  1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_FINAL,  8'h61, 1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_FINAL,  8'h21, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_FINAL,  8'h09, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_DONE,   8'h00, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_FINAL,  8'h00, 1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_CLEAR,  8'h00, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b1, 1'b1, 1'b0, 10'd0},
      '{crp_pkg::FUNC_STREAM, 8'h7f, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0, 10'd0},
      '{crp_pkg::FUNC_SHOW,   8'h00, 1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 10'd0}
    };
    caps = '{1, 0, 127, 3, 64, 17, 65};
    clear_caption();
    capacity = 65;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      before_q = caption_q.size();
      send_word(rows[i].f, rows[i].tb, rows[i].first, rows[i].cnt, rows[i].frc);
      if (rows[i].chk) begin
        w = caption_q[caption_q.size() - 1];
        if (caption_q.size() != before_q + 1 || w.v !== rows[i].exp_v || w.l !== 1'b1 ||
            w.vis !== rows[i].exp_vis) begin
          $error("directed row %0d: empty caption with visible_sequences %0d expected", i,
                 rows[i].exp_vis);
          errors++;
        end
      end
    end

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      while (items_sent < 25 + 25 * (p + 1)) begin
        if ($urandom_range(0, 4) == 0) noise_word();
        else caption_episode();
      end
    end

    in_valid <= 1'b0;
    while (caption_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && caption_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: caption_pacing_reveal.f
hw/rtl/crp_pkg.sv
hw/rtl/crp_front.sv
hw/rtl/crp_fifo.sv
hw/rtl/crp_back.sv
hw/rtl/caption_pacing_reveal.sv
hw/rtl/crp_checker.sv
verif/testbench.sv
